// ----- rtl/core/svpd_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// svpd_pkg - space vector PWM duty unit: shared types and constants
// Widths of the fixed-point datapath, sector codes and the divider beat.
// ============================================================================
package svpd_pkg;

   // input sample width; samples are aligned to Q1.15 on entry
   localparam int SAMPLE_BITS = 16;
   localparam int Q_W         = 16;

   // projections p = 1.5*alpha and q = (sqrt3/2)*beta, units of 2^-31
   localparam int PROD_W = 34;

   // active times, their sum and the divisor
   localparam int T_W = 34;

   // divider remainder and quotient, one quotient bit per stage
   localparam int REM_W      = T_W + 1;
   localparam int QUO_W      = 32;
   localparam int DIV_STAGES = QUO_W;

   // on-fractions in units of 2^-32, at most 2^32
   localparam int F_W = 33;

   localparam int PERIOD_W  = 16;
   localparam int CMP_W     = 16;
   localparam int CMP_SHIFT = 32;
   localparam int SECTOR_W  = 3;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 16'd1700;
   localparam logic [15:0]         HALF_SQRT3_Q16 = 16'd56756;
   localparam logic [T_W-1:0]      ONE_Q31        = T_W'(64'h8000_0000);

   typedef enum logic [SECTOR_W-1:0] {
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5,
      SECTOR_6 = 3'd6
   } sector_type;

   typedef struct packed {
      sector_type     sector;
      logic           ovm;
      logic [T_W-1:0] t1;
      logic [T_W-1:0] t2;
   } div_item_type;

endpackage

// ----- rtl/core/svpd_div.sv -----
`timescale 1ns / 1ps
// ============================================================================
// svpd_div - pipelined restoring divider for overmodulation rescaling
// Computes floor(t1 * 2^31 / divisor), one quotient bit per stage, and
// carries the beat alongside. Bubbles collapse; stalls hold each stage.
// ============================================================================
module svpd_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            up_valid,
   output logic                            up_ready,
   input  svpd_pkg::div_item_type          up_item,
   input  logic [svpd_pkg::T_W-1:0]        up_divisor,
   output logic                            dn_valid,
   input  logic                            dn_ready,
   output svpd_pkg::div_item_type          dn_item,
   output logic [svpd_pkg::QUO_W-1:0]      dn_quot
);

   localparam int LAST = svpd_pkg::DIV_STAGES - 1;

   logic                             v_ff    [svpd_pkg::DIV_STAGES];
   logic                             rdy     [svpd_pkg::DIV_STAGES];
   logic [svpd_pkg::REM_W-1:0]       rem_ff  [svpd_pkg::DIV_STAGES];
   logic [svpd_pkg::T_W-1:0]         div_ff  [svpd_pkg::DIV_STAGES];
   logic [svpd_pkg::QUO_W-1:0]       quot_ff [svpd_pkg::DIV_STAGES];
   svpd_pkg::div_item_type           item_ff [svpd_pkg::DIV_STAGES];

   for (genvar k = 0; k < svpd_pkg::DIV_STAGES; k++) begin : g_stage
      logic                        src_v;
      svpd_pkg::div_item_type      src_item;
      logic [svpd_pkg::REM_W-1:0]  src_rem;
      logic [svpd_pkg::T_W-1:0]    src_div;
      logic [svpd_pkg::QUO_W-1:0]  src_quot;
      logic                        nxt_rdy;
      logic                        ge;
      logic [svpd_pkg::REM_W-1:0]  rem_in;
      logic [svpd_pkg::QUO_W-1:0]  quot_in;

      if (k == 0) begin : g_first
         assign src_v    = up_valid;
         assign src_item = up_item;
         assign src_rem  = {1'b0, up_item.t1};
         assign src_div  = up_divisor;
         assign src_quot = '0;
      end else begin : g_next
         assign src_v    = v_ff[k-1];
         assign src_item = item_ff[k-1];
         assign src_rem  = {rem_ff[k-1][svpd_pkg::REM_W-2:0], 1'b0};
         assign src_div  = div_ff[k-1];
         assign src_quot = quot_ff[k-1];
      end

      if (k == LAST) begin : g_tail
         assign nxt_rdy = dn_ready;
      end else begin : g_mid
         assign nxt_rdy = rdy[k+1];
      end

      assign rdy[k]  = !v_ff[k] || nxt_rdy;
      assign ge      = src_rem >= {1'b0, src_div};
      assign rem_in  = ge ? (src_rem - {1'b0, src_div}) : src_rem;
      assign quot_in = {src_quot[svpd_pkg::QUO_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k] && src_v) begin
            rem_ff[k]  <= rem_in;
            div_ff[k]  <= src_div;
            quot_ff[k] <= quot_in;
            item_ff[k] <= src_item;
         end
      end
   end

   assign up_ready = rdy[0];
   assign dn_valid = v_ff[LAST];
   assign dn_item  = item_ff[LAST];
   assign dn_quot  = quot_ff[LAST];

`ifndef NO_ASSERTIONS
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      v_ff[LAST] && item_ff[LAST].ovm |-> rem_ff[LAST] < {1'b0, div_ff[LAST]})
      else $error("divider remainder not below divisor");

   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      dn_valid && dn_item.ovm |->
         {{(svpd_pkg::T_W-svpd_pkg::QUO_W){1'b0}}, dn_quot} <= svpd_pkg::ONE_Q31)
      else $error("rescaled T1 exceeds the period");

   a_dn_hold: assert property (@(posedge clock) disable iff (reset)
      dn_valid && !dn_ready |=> dn_valid && $stable(dn_quot))
      else $error("stalled divider output changed");
`endif

endmodule

// ----- rtl/core/space_vector_pwm_duty_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// space_vector_pwm_duty_unit - seven-segment space vector PWM compare values
// Sector search, active times, overmodulation rescale and centre-aligned
// compare values for phases A, B and C, scaled to the carrier period.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | valpha, vbeta (Q1.15)
//   rsp     | out       | rsp_valid/stall    | compare_a/b/c, sector, ovm flag
//   csr     | in        | csr_wr_en          | carrier period
//
// One beat per cycle sustained while rsp_stall is low; the pipeline is the 32-stage
// divider (one quotient bit per stage) plus six datapath stages.
// Reset empties the pipeline and loads a period of 1700 counts.
// A stalled result holds; upstream stages keep filling empty slots.
// ============================================================================
module space_vector_pwm_duty_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [svpd_pkg::SAMPLE_BITS-1:0] req_valpha,
   input  logic signed [svpd_pkg::SAMPLE_BITS-1:0] req_vbeta,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [svpd_pkg::CMP_W-1:0]            rsp_compare_a,
   output logic [svpd_pkg::CMP_W-1:0]            rsp_compare_b,
   output logic [svpd_pkg::CMP_W-1:0]            rsp_compare_c,
   output logic [svpd_pkg::SECTOR_W-1:0]         rsp_sector_number,
   output logic                                  rsp_overmodulated,
   input  logic                                  csr_wr_en,
   input  logic [svpd_pkg::PERIOD_W-1:0]         csr_wr_data
);

   localparam int SB = svpd_pkg::SAMPLE_BITS;
   localparam int QW = svpd_pkg::Q_W;
   localparam int PW = svpd_pkg::PROD_W;
   localparam int FW = svpd_pkg::F_W;

   logic [svpd_pkg::PERIOD_W-1:0] period_ff;

   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

   // stage 1: aligned samples
   logic                  v1_ff;
   logic signed [QW-1:0]  a_ff, b_ff, a_in, b_in;
   logic [SB+QW-1:0]      a_pad, b_pad;

   // stage 2: projections
   logic                  v2_ff;
   logic signed [PW-1:0]  p_ff, q_ff, p_in, q_in, a_ext;
   logic signed [QW+16:0] q_prod;
   logic                  upper_ff, upper_in;

   // stage 3: sector and active times
   logic                  v3_ff;
   svpd_pkg::sector_type  sec3_ff, sec3_in;
   logic [svpd_pkg::T_W-1:0] t1_ff, t2_ff, t1_in, t2_in;
   logic signed [PW-1:0]  pq_sum, pq_diff, q2;

   // stage 4: sum and overmodulation
   logic                  v4_ff;
   svpd_pkg::div_item_type item4_ff, item4_in;
   logic [svpd_pkg::T_W-1:0] sum_ff, sum_in;

   // divider output
   logic                  div_up_ready, div_dn_valid;
   svpd_pkg::div_item_type div_item;
   logic [svpd_pkg::QUO_W-1:0] div_quot;

   // stage 5: on-fractions
   logic                  v5_ff;
   logic [FW-1:0]         fa_ff, fb_ff, fc_ff, fa_in, fb_in, fc_in;
   logic [FW-1:0]         t1f, t2f, t0f, hi, m1, m2, one_f;
   svpd_pkg::sector_type  sec5_ff;
   logic                  ovm5_ff;

   // stage 6: result register
   logic                  rsp_valid_ff;
   logic [svpd_pkg::CMP_W-1:0] cmp_a_ff, cmp_b_ff, cmp_c_ff;
   logic [svpd_pkg::CMP_W-1:0] cmp_a_in, cmp_b_in, cmp_c_in;
   logic [FW+svpd_pkg::PERIOD_W-1:0] prod_a, prod_b, prod_c;
   svpd_pkg::sector_type  sec6_ff;
   logic                  ovm6_ff;

   // period register
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= svpd_pkg::PERIOD_RESET;
      end else if (csr_wr_en) begin
         period_ff <= csr_wr_data;
      end
   end

   // ready chain, bubbles collapse
   assign rdy6      = !rsp_valid_ff || !rsp_stall;
   assign rdy5      = !v5_ff || rdy6;
   assign rdy4      = !v4_ff || div_up_ready;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = !rdy1;

   // stage 1
   assign a_pad = {req_valpha, {QW{1'b0}}};
   assign b_pad = {req_vbeta, {QW{1'b0}}};
   assign a_in  = a_pad[SB+QW-1 -: QW];
   assign b_in  = b_pad[SB+QW-1 -: QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_valid) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   // stage 2: p = 1.5*a*2^16, q = b*56756
   assign a_ext    = PW'(a_ff);
   assign p_in     = (a_ext <<< 16) + (a_ext <<< 15);
   assign q_prod   = b_ff * $signed({1'b0, svpd_pkg::HALF_SQRT3_Q16});
   assign q_in     = PW'(q_prod);
   assign upper_in = !b_ff[QW-1] && ((b_ff != '0) || !a_ff[QW-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         p_ff     <= p_in;
         q_ff     <= q_in;
         upper_ff <= upper_in;
      end
   end

   // stage 3: sector table
   assign pq_sum  = p_ff + q_ff;
   assign pq_diff = p_ff - q_ff;
   assign q2      = q_ff <<< 1;

   always_comb begin
      if (upper_ff) begin
         if (!pq_diff[PW-1]) begin
            sec3_in = svpd_pkg::SECTOR_1;
            t1_in   = pq_diff;
            t2_in   = q2;
         end else if (!pq_sum[PW-1]) begin
            sec3_in = svpd_pkg::SECTOR_2;
            t1_in   = pq_sum;
            t2_in   = -pq_diff;
         end else begin
            sec3_in = svpd_pkg::SECTOR_3;
            t1_in   = q2;
            t2_in   = -pq_sum;
         end
      end else begin
         if (pq_diff[PW-1] || (pq_diff == '0)) begin
            sec3_in = svpd_pkg::SECTOR_4;
            t1_in   = -pq_diff;
            t2_in   = -q2;
         end else if (pq_sum[PW-1] || (pq_sum == '0)) begin
            sec3_in = svpd_pkg::SECTOR_5;
            t1_in   = -pq_sum;
            t2_in   = pq_diff;
         end else begin
            sec3_in = svpd_pkg::SECTOR_6;
            t1_in   = -q2;
            t2_in   = pq_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         sec3_ff <= sec3_in;
         t1_ff   <= t1_in;
         t2_ff   <= t2_in;
      end
   end

   // stage 4: overmodulation test
   assign sum_in          = t1_ff + t2_ff;
   assign item4_in.sector = sec3_ff;
   assign item4_in.ovm    = sum_in > svpd_pkg::ONE_Q31;
   assign item4_in.t1     = t1_ff;
   assign item4_in.t2     = t2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (rdy4) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         item4_ff <= item4_in;
         sum_ff   <= sum_in;
      end
   end

   svpd_div u_div (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (v4_ff),
      .up_ready   (div_up_ready),
      .up_item    (item4_ff),
      .up_divisor (sum_ff),
      .dn_valid   (div_dn_valid),
      .dn_ready   (rdy5),
      .dn_item    (div_item),
      .dn_quot    (div_quot)
   );

   // stage 5: zero time and phase on-fractions
   assign one_f = FW'(svpd_pkg::ONE_Q31);
   assign t1f   = div_item.ovm ? FW'(div_quot) : FW'(div_item.t1);
   assign t2f   = div_item.ovm ? (one_f - FW'(div_quot)) : FW'(div_item.t2);
   assign t0f   = one_f - t1f - t2f;
   assign hi    = one_f + t1f + t2f;
   assign m1    = one_f + t1f - t2f;
   assign m2    = one_f + t2f - t1f;

   always_comb begin
      case (div_item.sector)
         svpd_pkg::SECTOR_1: begin
            fa_in = hi;  fb_in = m2;  fc_in = t0f;
         end
         svpd_pkg::SECTOR_2: begin
            fa_in = m1;  fb_in = hi;  fc_in = t0f;
         end
         svpd_pkg::SECTOR_3: begin
            fa_in = t0f; fb_in = hi;  fc_in = m2;
         end
         svpd_pkg::SECTOR_4: begin
            fa_in = t0f; fb_in = m1;  fc_in = hi;
         end
         svpd_pkg::SECTOR_5: begin
            fa_in = m2;  fb_in = t0f; fc_in = hi;
         end
         default: begin
            fa_in = hi;  fb_in = t0f; fc_in = m1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (rdy5) begin
         v5_ff <= div_dn_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5 && div_dn_valid) begin
         fa_ff   <= fa_in;
         fb_ff   <= fb_in;
         fc_ff   <= fc_in;
         sec5_ff <= div_item.sector;
         ovm5_ff <= div_item.ovm;
      end
   end

   // stage 6: scale to the carrier period
   assign prod_a   = fa_ff * period_ff;
   assign prod_b   = fb_ff * period_ff;
   assign prod_c   = fc_ff * period_ff;
   assign cmp_a_in = prod_a[svpd_pkg::CMP_SHIFT +: svpd_pkg::CMP_W];
   assign cmp_b_in = prod_b[svpd_pkg::CMP_SHIFT +: svpd_pkg::CMP_W];
   assign cmp_c_in = prod_c[svpd_pkg::CMP_SHIFT +: svpd_pkg::CMP_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rdy6) begin
         rsp_valid_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy6 && v5_ff) begin
         cmp_a_ff <= cmp_a_in;
         cmp_b_ff <= cmp_b_in;
         cmp_c_ff <= cmp_c_in;
         sec6_ff  <= sec5_ff;
         ovm6_ff  <= ovm5_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_compare_a     = cmp_a_ff;
   assign rsp_compare_b     = cmp_b_ff;
   assign rsp_compare_c     = cmp_c_ff;
   assign rsp_sector_number = sec6_ff;
   assign rsp_overmodulated = ovm6_ff;

`ifndef NO_ASSERTIONS
   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (sec3_ff >= svpd_pkg::SECTOR_1) && (sec3_ff <= svpd_pkg::SECTOR_6))
      else $error("sector out of range");

   a_duty_order: assert property (@(posedge clock) disable iff (reset)
      div_dn_valid |-> (hi >= m1) && (hi >= m2) && (m1 >= t0f) && (m2 >= t0f))
      else $error("phase on-fractions out of order");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !v1_ff && !v5_ff)
      else $error("pipeline not empty after reset");
`endif

endmodule
